// ----- design/dslp_pkg.sv -----
// dslp_pkg: shared constants, codes, types and the clamp-limit helper
// for the decimal sample line parser. No dependencies.
package dslp_pkg;

  localparam int DSLP_MAX_SAMPLE_BITS = 32;

  localparam int ACC_W    = 32;
  localparam int SAMPLE_W = 31;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int BITS_W   = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_CHAR = 2'd1;
  localparam logic [1:0] STAT_COUNT    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 8'd1;

  localparam logic [BITS_W-1:0]  SAMPLE_BITS_RST = 6'd16;
  localparam logic [COUNT_W-1:0] CHANNELS_RST    = 8'd2;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic               pend;
    logic [COUNT_W-1:0] count;
    logic               skip;
  } line_state_t;

  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] sample_value;
    logic                has_sample;
    logic [1:0]          status;
    logic                line_done;
  } result_t;

  // 2^(b-1)-1 with b capped at max_bits and floored at 1
  function automatic logic [SAMPLE_W-1:0] clamp_lim(input logic [BITS_W-1:0] bits,
                                                    input int max_bits);
    logic [BITS_W-1:0] b;
    b = bits;
    if (int'(bits) > max_bits) b = BITS_W'(max_bits);
    if (b == '0) b = BITS_W'(1);
    return ~({SAMPLE_W{1'b1}} << (b - BITS_W'(1)));
  endfunction

endpackage

// ----- design/dslp_channels.sv -----
// Handshake channel interfaces for the decimal sample line parser:
// character input, result output and register write. Uses dslp_pkg.
interface dslp_in_if import dslp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_line;
  modport source (output valid, char_code, end_of_line, input ready);
  modport sink   (input valid, char_code, end_of_line, output ready);
endinterface

interface dslp_out_if import dslp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_value;
  logic                has_sample;
  logic [1:0]          status;
  logic                line_done;
  modport source (output valid, sample_value, has_sample, status, line_done, input ready);
  modport sink   (input valid, sample_value, has_sample, status, line_done, output ready);
endinterface

interface dslp_cfg_if import dslp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- design/dslp_step.sv -----
// dslp_step: next line state and result word for one character.
// Pure combinational; uses dslp_pkg.
module dslp_step import dslp_pkg::*; (
  input  line_state_t         cur,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic                end_of_line,
  input  logic [SAMPLE_W-1:0] lim,
  input  logic [COUNT_W-1:0]  channels,
  output line_state_t         nxt,
  output result_t             res
);

  logic              above, below, is_digit, close;
  logic [ACC_W+3:0]  prod, cand;
  logic [ACC_W-1:0]  acc_new;
  logic              pend_new;
  logic [SAMPLE_W-1:0] val;
  logic [COUNT_W-1:0]  count_inc;

  assign above    = char_code > CH_NINE;
  assign below    = char_code < CH_ZERO;
  assign is_digit = !above && !below;

  // acc*10 + digit; low nibble of '0'..'9' is the digit
  assign prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
              + {{ACC_W{1'b0}}, char_code[3:0]};
  assign acc_new  = !is_digit ? cur.acc
                  : (prod[ACC_W+3:ACC_W] != '0) ? {ACC_W{1'b1}} : prod[ACC_W-1:0];
  assign pend_new = cur.pend || is_digit;
  assign close    = (below || end_of_line) && pend_new;

  // clamp straight from the unsaturated sum: anything past 2^32-1 is above lim
  assign cand = is_digit ? prod : {4'b0000, cur.acc};
  assign val  = (cand > {5'b00000, lim}) ? lim : cand[SAMPLE_W-1:0];

  assign count_inc = !close ? cur.count
                   : (cur.count == {COUNT_W{1'b1}}) ? cur.count : cur.count + COUNT_W'(1);

  always_comb begin
    nxt = '0;
    res = '0;
    if (cur.skip) begin
      nxt.skip = !end_of_line;
    end else if (above) begin
      res.valid     = 1'b1;
      res.status    = STAT_BAD_CHAR;
      res.line_done = 1'b1;
      nxt.skip      = !end_of_line;
    end else if (end_of_line) begin
      res.valid        = 1'b1;
      res.sample_value = close ? val : '0;
      res.has_sample   = close;
      res.status       = (count_inc != channels) ? STAT_COUNT : STAT_OK;
      res.line_done    = 1'b1;
    end else if (close) begin
      res.valid        = 1'b1;
      res.sample_value = val;
      res.has_sample   = 1'b1;
      res.status       = STAT_OK;
      nxt.count        = count_inc;
    end else begin
      nxt.acc   = acc_new;
      nxt.pend  = pend_new;
      nxt.count = cur.count;
    end
  end

endmodule

// ----- design/decimal_sample_line_parser.sv -----
// decimal_sample_line_parser: top level; line state, register file and
// output word register. Uses dslp_pkg, dslp_channels, dslp_step.
//
//  channel  | dir | word fields                                   | notes
//  in_ch    | in  | char_code[7:0], end_of_line                   | one char per word
//  out_ch   | out | sample_value[30:0], has_sample, status[1:0],  | zero or one word
//           |     | line_done                                     | per input word
//  cfg_ch   | in  | reg_index[7:0], wdata[31:0]                   | 0 sample_bits,
//           |     |                                               | 1 channels_expected
//
// One input word per cycle while in_ch.ready is high; its result word shows in the next cycle.
// The rate is set by the combinational step logic (x10 add, saturate, clamp compare).
// in_ch.ready is low only while a result word sits in the output register and
// out_ch.ready is low. cfg_ch is always ready.
// rst_n (synchronous, active low) clears line state and the output valid flag and
// loads sample_bits 16, channels_expected 2.
module decimal_sample_line_parser import dslp_pkg::*; #(
  parameter int MAX_SAMPLE_BITS = DSLP_MAX_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  dslp_in_if.sink     in_ch,
  dslp_out_if.source  out_ch,
  dslp_cfg_if.sink    cfg_ch
);

  // line state
  line_state_t st_r, st_nxt, step_nxt;
  result_t     res;

  // config: clamp limit is kept precomputed, off the per-character path
  logic [SAMPLE_W-1:0] lim_r, lim_nxt;
  logic [COUNT_W-1:0]  chan_r, chan_nxt;

  // output word register
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_value_r, out_value_nxt;
  logic                out_has_r, out_has_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic                out_done_r, out_done_nxt;

  logic in_acc, cfg_acc;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  dslp_step u_step (
    .cur         (st_r),
    .char_code   (in_ch.char_code),
    .end_of_line (in_ch.end_of_line),
    .lim         (lim_r),
    .channels    (chan_r),
    .nxt         (step_nxt),
    .res         (res)
  );

  always_comb begin
    st_nxt   = in_acc ? step_nxt : st_r;
    lim_nxt  = lim_r;
    chan_nxt = chan_r;
    if (cfg_acc) begin
      case (cfg_ch.reg_index)
        REG_SAMPLE_BITS: lim_nxt  = clamp_lim(cfg_ch.wdata[BITS_W-1:0], MAX_SAMPLE_BITS);
        REG_CHANNELS:    chan_nxt = cfg_ch.wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a new word overwrites the register; otherwise it drains when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    out_done_nxt   = out_done_r;
    if (in_acc) begin
      out_valid_nxt  = res.valid;
      out_value_nxt  = res.sample_value;
      out_has_nxt    = res.has_sample;
      out_status_nxt = res.status;
      out_done_nxt   = res.line_done;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      lim_r       <= clamp_lim(SAMPLE_BITS_RST, MAX_SAMPLE_BITS);
      chan_r      <= CHANNELS_RST;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      lim_r       <= lim_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = out_value_r;
  assign out_ch.has_sample   = out_has_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.line_done    = out_done_r;

  // skipping a line means all other line state was already cleared
  a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.skip |-> (st_r.acc == '0 && !st_r.pend && st_r.count == '0))
    else $error("skip set with live line state");

  // emitted samples never exceed the configured clamp limit
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_r) |-> (out_value_r <= lim_r))
    else $error("sample above clamp limit");

  // a bad character closes the line and carries no sample
  a_bad_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_BAD_CHAR) |-> (out_done_r && !out_has_r))
    else $error("bad-character word malformed");

  // characters swallowed while skipping leave no result word behind
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && st_r.skip) |=> !out_valid_r)
    else $error("result produced while skipping");

endmodule
